// ===== rtl/rtal_pkg.sv =====
`timescale 1ns / 1ps

package rtal_pkg;

    localparam int TAG_W  = 40;
    localparam int TO_W   = 16;
    localparam int MODE_W = 3;
    localparam int BEEP_W = 2;
    localparam int OUT_SLOT_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam int SLOTS_DEFAULT = 5;
    localparam int MASTER_SLOT   = 1;
    localparam int SUB_SLOT      = 2;
    localparam int FIRST_USER_SLOT = 3;

    localparam logic [MODE_W-1:0] MODE_PWON  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RPROG = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_USER  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_TO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_TO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPROGRAM_TO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ID    = 2'd3;

    localparam logic [TO_W-1:0]  POWER_ON_TO_RST  = 16'd200;
    localparam logic [TO_W-1:0]  ALERT_TO_RST     = 16'd200;
    localparam logic [TO_W-1:0]  REPROGRAM_TO_RST = 16'd100;
    localparam logic [TAG_W-1:0] MASTER_ID_RST    = 40'd13102791;
    localparam logic [TAG_W-1:0] TAG_ERASED       = {TAG_W{1'b1}};

    localparam logic [BEEP_W-1:0] BEEP_NONE   = 2'd0;
    localparam logic [BEEP_W-1:0] BEEP_ONE    = 2'd1;
    localparam logic [BEEP_W-1:0] BEEP_USER   = 2'd2;
    localparam logic [BEEP_W-1:0] BEEP_MASTER = 2'd3;

    typedef struct packed {
        logic load;
        logic wr;
        logic erase;
    } cell_ctrl_t;

endpackage

// ===== rtl/rfid_tag_access_learner.sv =====
`timescale 1ns / 1ps

// Tag access learner. A transaction (start high while busy is low) carries one
// reader pass; busy stays low, so a transaction may be issued in every cycle.
// Its result appears in the cycle after acceptance on the result ports, marked by
// done for exactly one cycle; the receiver cannot stall, so it must take the
// result in that cycle. The tag is matched in the same cycle across the row of
// slot cells, lowest slot first, and the mode update completes in that cycle.
// Configuration writes are always ready; alert and reprogram timeouts take effect
// at once, power_on_timeout writes are dropped, and default_master_id also loads slot 1.

module rfid_tag_access_learner
    import rtal_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  tag_present,
    input  logic [TAG_W-1:0]      tag_code,
    output logic                  done,
    output logic                  unlock,
    output logic                  alarm_on,
    output logic                  tone_high,
    output logic [BEEP_W-1:0]     beep_request,
    output logic [MODE_W-1:0]     mode_now,
    output logic [OUT_SLOT_W-1:0] matched_slot,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HW = $clog2(SLOTS + 1);
    localparam int LW = $clog2(SLOTS + 2);

    logic acc;
    logic cfg_we;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic [TO_W-1:0]   tick_reg;
    logic [TO_W-1:0]   tick_next;
    logic [TO_W-1:0]   limit_reg;
    logic [TO_W-1:0]   limit_next;
    logic [LW-1:0]     learn_reg;
    logic [LW-1:0]     learn_next;
    logic              held_reg;
    logic              tone_reg;
    logic              tone_next;
    logic [TO_W-1:0]   alert_to_reg;
    logic [TO_W-1:0]   rprog_to_reg;

    logic                  done_reg;
    logic                  unlock_reg;
    logic                  alarm_reg;
    logic                  tone_out_reg;
    logic [BEEP_W-1:0]     beep_reg;
    logic [MODE_W-1:0]     mode_out_reg;
    logic [OUT_SLOT_W-1:0] slot_out_reg;

    logic [HW-1:0]     hit_chain [SLOTS+1];
    logic [HW-1:0]     hit;
    logic [TO_W-1:0]   tick_mid;
    logic [LW-1:0]     store_slot;
    logic              store_wr;
    logic              erase_sub;
    logic              erase_user;
    logic [BEEP_W-1:0] beeps;
    logic [TAG_W-1:0]  wr_code;
    logic              load_master;

    cell_ctrl_t cell_ctrl [SLOTS];

    assign acc       = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign load_master = cfg_we && (cfg_index == CFG_MASTER_ID);
    assign wr_code     = load_master ? cfg_data[TAG_W-1:0] : tag_code;

    assign hit_chain[0] = '0;
    assign hit = tag_present ? hit_chain[SLOTS] : '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            assign cell_ctrl[g].load  = load_master && (g == 0);
            assign cell_ctrl[g].wr    = acc && store_wr && (store_slot == LW'(g + 1));
            assign cell_ctrl[g].erase = acc && ((erase_sub && (g + 1 >= SUB_SLOT))
                                     || (erase_user && (g + 1 >= FIRST_USER_SLOT)));

            rtal_cell #(
                .IDX      (g + 1),
                .HW       (HW),
                .RST_CODE ((g == 0) ? MASTER_ID_RST : TAG_ERASED)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl[g]),
                .wr_code    (wr_code),
                .probe_code (tag_code),
                .hit_in     (hit_chain[g]),
                .hit_out    (hit_chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        mode_next  = mode_reg;
        tick_mid   = tick_reg;
        limit_next = limit_reg;
        learn_next = learn_reg;
        tone_next  = tone_reg;
        beeps      = BEEP_NONE;
        erase_sub  = 1'b0;
        erase_user = 1'b0;
        store_wr   = 1'b0;
        store_slot = (learn_reg <= LW'(SLOTS)) ? learn_reg + LW'(1) : learn_reg;

        if (tag_present)
        begin
            unique case (mode_reg)
                MODE_PWON, MODE_ALERT:
                begin
                    if (hit > HW'(MASTER_SLOT))
                    begin
                        mode_next  = MODE_OPEN;
                        tick_mid   = '0;
                        limit_next = '0;
                    end
                    else if (hit == HW'(MASTER_SLOT))
                    begin
                        erase_sub  = 1'b1;
                        mode_next  = MODE_SUB;
                        tick_mid   = '0;
                        limit_next = '0;
                        learn_next = LW'(MASTER_SLOT);
                        beeps      = BEEP_MASTER;
                    end
                end
                MODE_RPROG:
                begin
                    if (!held_reg && hit == HW'(MASTER_SLOT))
                    begin
                        erase_sub  = 1'b1;
                        mode_next  = MODE_SUB;
                        tick_mid   = '0;
                        limit_next = '0;
                        learn_next = LW'(MASTER_SLOT);
                        beeps      = BEEP_MASTER;
                    end
                    else if (!held_reg && hit == HW'(SUB_SLOT))
                    begin
                        erase_user = 1'b1;
                        mode_next  = MODE_USER;
                        tick_mid   = '0;
                        limit_next = '0;
                        learn_next = LW'(SUB_SLOT);
                        beeps      = BEEP_USER;
                    end
                end
                MODE_SUB, MODE_USER:
                begin
                    if (held_reg)
                    begin
                        beeps = BEEP_ONE;
                    end
                    else if ((mode_reg == MODE_SUB && hit != HW'(MASTER_SLOT))
                          || (mode_reg == MODE_USER
                              && (hit == '0 || hit > HW'(SUB_SLOT))))
                    begin
                        learn_next = store_slot;
                        if (store_slot != '0 && store_slot <= LW'(SLOTS))
                        begin
                            store_wr = 1'b1;
                            tick_mid = '0;
                            beeps    = BEEP_ONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // advance on timeout
        if (limit_next != '0 && tick_mid > limit_next)
        begin
            priority if (mode_next == MODE_PWON)
            begin
                mode_next  = MODE_ALERT;
                tick_mid   = '0;
                limit_next = alert_to_reg;
            end
            else if (mode_next == MODE_ALERT)
            begin
                mode_next  = MODE_RPROG;
                tick_mid   = '0;
                limit_next = rprog_to_reg;
            end
            else if (mode_next == MODE_RPROG)
            begin
                mode_next  = MODE_ALERT;
                tick_mid   = '0;
                limit_next = '0;
            end
        end

        if (mode_next == MODE_ALERT && tick_mid[1:0] == 2'b00)
        begin
            tone_next = ~tone_reg;
        end

        tick_next = tick_mid + TO_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_PWON;
            tick_reg     <= '0;
            limit_reg    <= POWER_ON_TO_RST;
            learn_reg    <= '0;
            held_reg     <= 1'b0;
            tone_reg     <= 1'b0;
            done_reg     <= 1'b0;
            alert_to_reg <= ALERT_TO_RST;
            rprog_to_reg <= REPROGRAM_TO_RST;
        end
        else
        begin
            done_reg <= acc;
            if (acc)
            begin
                mode_reg  <= mode_next;
                tick_reg  <= tick_next;
                limit_reg <= limit_next;
                learn_reg <= learn_next;
                held_reg  <= tag_present;
                tone_reg  <= tone_next;
            end
            // power_on_timeout only seeds the reset limit; drop later writes
            if (cfg_we && cfg_index == CFG_ALERT_TO)
            begin
                alert_to_reg <= cfg_data[TO_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_REPROGRAM_TO)
            begin
                rprog_to_reg <= cfg_data[TO_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            unlock_reg   <= (mode_next == MODE_OPEN);
            alarm_reg    <= (mode_next == MODE_ALERT);
            tone_out_reg <= tone_next;
            beep_reg     <= beeps;
            mode_out_reg <= mode_next;
            slot_out_reg <= OUT_SLOT_W'(hit);
        end
    end

    assign done         = done_reg;
    assign unlock       = unlock_reg;
    assign alarm_on     = alarm_reg;
    assign tone_high    = tone_out_reg;
    assign beep_request = beep_reg;
    assign mode_now     = mode_out_reg;
    assign matched_slot = slot_out_reg;

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start))
        else $error("result without a transaction");

    a_lock_alarm_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(unlock && alarm_on))
        else $error("unlock and alarm together");

    a_unlock_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && unlock) |-> (mode_now == MODE_OPEN))
        else $error("unlock outside open mode");

    a_master_beeps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && beep_request == BEEP_MASTER) |->
            (mode_now == MODE_SUB && matched_slot == OUT_SLOT_W'(MASTER_SLOT)))
        else $error("master beeps without master tag");

endmodule

// ===== rtl/rtal_cell.sv =====
`timescale 1ns / 1ps

module rtal_cell
    import rtal_pkg::*;
#(
    parameter int               IDX      = 1,
    parameter int               HW       = 3,
    parameter logic [TAG_W-1:0] RST_CODE = TAG_ERASED
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [TAG_W-1:0] wr_code,
    input  logic [TAG_W-1:0] probe_code,
    input  logic [HW-1:0]    hit_in,
    output logic [HW-1:0]    hit_out
);

    logic [TAG_W-1:0] entry_reg;
    logic [TAG_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load || ctrl.wr)
        begin
            entry_next = wr_code;
        end
        else if (ctrl.erase)
        begin
            entry_next = TAG_ERASED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= RST_CODE;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    // keep the lowest matching slot seen so far
    assign hit_out = (hit_in != '0) ? hit_in
                   : ((entry_reg == probe_code) ? HW'(IDX) : '0);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rtal_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic                  unlock;
        logic                  alarm_on;
        logic                  tone_high;
        logic [BEEP_W-1:0]     beeps;
        logic [MODE_W-1:0]     mode;
        logic [OUT_SLOT_W-1:0] slot;
    } pass_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  tag_present = 1'b0;
    logic [TAG_W-1:0]      tag_code = '0;
    logic                  done;
    logic                  unlock;
    logic                  alarm_on;
    logic                  tone_high;
    logic [BEEP_W-1:0]     beep_request;
    logic [MODE_W-1:0]     mode_now;
    logic [OUT_SLOT_W-1:0] matched_slot;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // lock state as predicted from the accepted passes
    logic [MODE_W-1:0] lk_mode;
    logic [TO_W-1:0]   lk_ticks;
    logic [TO_W-1:0]   lk_limit;
    int unsigned       lk_learn;
    logic              lk_held;
    logic              lk_tone;
    logic [TAG_W-1:0]  lk_table [1:SLOTS];
    logic [TO_W-1:0]   alert_limit_reg;
    logic [TO_W-1:0]   rprog_limit_reg;

    pass_result_t pending_passes[$];
    int           errors = 0;
    int unsigned  cycle_count = 0;
    int           burst_left = 0;
    bit           steady = 1'b0;

    rfid_tag_access_learner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .tag_present  (tag_present),
        .tag_code     (tag_code),
        .done         (done),
        .unlock       (unlock),
        .alarm_on     (alarm_on),
        .tone_high    (tone_high),
        .beep_request (beep_request),
        .mode_now     (mode_now),
        .matched_slot (matched_slot),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int slot_of(input logic [TAG_W-1:0] code);
        for (int s = 1; s <= SLOTS; s++)
        begin
            if (lk_table[s] == code)
                return s;
        end
        return 0;
    endfunction

    function automatic void switch_mode(input logic [MODE_W-1:0] m, input logic [TO_W-1:0] lim);
        lk_mode  = m;
        lk_ticks = '0;
        lk_limit = lim;
    endfunction

    function automatic void wipe_slots(input int first);
        for (int s = first; s <= SLOTS; s++)
            lk_table[s] = TAG_ERASED;
    endfunction

    function automatic logic [BEEP_W-1:0] store_learned(input logic [TAG_W-1:0] code);
        if (lk_learn <= SLOTS)
            lk_learn++;
        if (lk_learn >= 1 && lk_learn <= SLOTS)
        begin
            lk_table[lk_learn] = code;
            lk_ticks = '0;
            return BEEP_ONE;
        end
        return BEEP_NONE;
    endfunction

    function automatic pass_result_t lock_pass(input logic present, input logic [TAG_W-1:0] code);
        pass_result_t      res;
        int                hit;
        logic [BEEP_W-1:0] beeps;
        hit   = 0;
        beeps = BEEP_NONE;
        if (present)
        begin
            hit = slot_of(code);
            case (lk_mode)
                MODE_PWON, MODE_ALERT:
                begin
                    if (hit > MASTER_SLOT)
                        switch_mode(MODE_OPEN, '0);
                    else if (hit == MASTER_SLOT)
                    begin
                        wipe_slots(SUB_SLOT);
                        switch_mode(MODE_SUB, '0);
                        lk_learn = MASTER_SLOT;
                        beeps = BEEP_MASTER;
                    end
                end
                MODE_RPROG:
                begin
                    if (!lk_held && hit == MASTER_SLOT)
                    begin
                        wipe_slots(SUB_SLOT);
                        switch_mode(MODE_SUB, '0);
                        lk_learn = MASTER_SLOT;
                        beeps = BEEP_MASTER;
                    end
                    else if (!lk_held && hit == SUB_SLOT)
                    begin
                        wipe_slots(FIRST_USER_SLOT);
                        switch_mode(MODE_USER, '0);
                        lk_learn = SUB_SLOT;
                        beeps = BEEP_USER;
                    end
                end
                MODE_SUB:
                begin
                    if (lk_held)
                        beeps = BEEP_ONE;
                    else if (hit != MASTER_SLOT)
                        beeps = store_learned(code);
                end
                MODE_USER:
                begin
                    if (lk_held)
                        beeps = BEEP_ONE;
                    else if (hit == 0 || hit > SUB_SLOT)
                        beeps = store_learned(code);
                end
                default: ;
            endcase
            lk_held = 1'b1;
        end
        else
            lk_held = 1'b0;

        if (lk_limit != '0 && lk_ticks > lk_limit)
        begin
            if (lk_mode == MODE_PWON)
                switch_mode(MODE_ALERT, alert_limit_reg);
            else if (lk_mode == MODE_ALERT)
                switch_mode(MODE_RPROG, rprog_limit_reg);
            else if (lk_mode == MODE_RPROG)
                switch_mode(MODE_ALERT, '0);
        end

        if (lk_mode == MODE_ALERT && lk_ticks[1:0] == 2'd0)
            lk_tone = ~lk_tone;

        res.unlock    = (lk_mode == MODE_OPEN);
        res.alarm_on  = (lk_mode == MODE_ALERT);
        res.tone_high = lk_tone;
        res.beeps     = beeps;
        res.mode      = lk_mode;
        res.slot      = hit[OUT_SLOT_W-1:0];
        lk_ticks++;
        return res;
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return {8'($urandom_range(0, 255)), 32'($urandom())};
    endfunction

    function automatic logic [TAG_W-1:0] fresh_tag();
        logic [TAG_W-1:0] t;
        do
            t = rand_tag();
        while (slot_of(t) != 0);
        return t;
    endfunction

    task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pass_result_t want;
        if (done === 1'b1)
        begin
            if (pending_passes.size() == 0)
            begin
                $error("result with no pass pending");
                errors++;
            end
            else
            begin
                want = pending_passes.pop_front();
                check_field("unlock", 3'(want.unlock), 3'(unlock));
                check_field("alarm_on", 3'(want.alarm_on), 3'(alarm_on));
                check_field("tone_high", 3'(want.tone_high), 3'(tone_high));
                check_field("beep_request", 3'(want.beeps), 3'(beep_request));
                check_field("mode_now", want.mode, mode_now);
                check_field("matched_slot", want.slot, matched_slot);
            end
        end
    end

    task automatic send_item(input logic present, input logic [TAG_W-1:0] code);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start       <= 1'b1;
        tag_present <= present;
        tag_code    <= code;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        pending_passes.push_back(lock_pass(present, code));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_passes.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        case (idx)
            CFG_ALERT_TO:     alert_limit_reg = data[TO_W-1:0];
            CFG_REPROGRAM_TO: rprog_limit_reg = data[TO_W-1:0];
            CFG_MASTER_ID:    lk_table[MASTER_SLOT] = data[TAG_W-1:0];
            default: ;  // power-on limit loads only at reset
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_register_writes();
        write_reg(CFG_POWER_ON_TO, '0);
        write_reg(CFG_ALERT_TO, 40'd12);
        write_reg(CFG_REPROGRAM_TO, 40'd20);
        write_reg(CFG_MASTER_ID, 40'h80_0000_0001);
    endtask

    task automatic test_power_on_timeout();
        logic [TAG_W-1:0] seen;
        send_item(1'b0, '0);
        send_item(1'b1, '0);
        send_item(1'b1, 40'h55_5555_5555);
        send_item(1'b1, 40'hAA_AAAA_AAAA);
        send_item(1'b1, 40'hFF_FFFF_FFFE);
        send_item(1'b1, 40'h00_0000_0001);
        send_item(1'b1, 40'h80_0000_0000);
        send_item(1'b0, TAG_ERASED);
        seen = fresh_tag();
        repeat (3) send_item(1'b1, seen);
        while (lk_mode == MODE_PWON)
            send_item(1'($urandom_range(0, 1)), fresh_tag());
    endtask

    task automatic test_alert_tone();
        while (lk_mode == MODE_ALERT)
            send_item(1'($urandom_range(0, 1)), fresh_tag());
    endtask

    task automatic test_reprogram_window();
        // known tags only while held, so the window runs out on its timer
        send_item(1'b1, fresh_tag());
        send_item(1'b1, lk_table[MASTER_SLOT]);
        send_item(1'b1, TAG_ERASED);
        send_item(1'b0, '0);
        while (lk_mode == MODE_RPROG)
        begin
            if (lk_held && $urandom_range(0, 2) == 0)
                send_item(1'b1, $urandom_range(0, 1) ? lk_table[MASTER_SLOT] : TAG_ERASED);
            else
                send_item(1'($urandom_range(0, 1)), fresh_tag());
        end
    endtask

    task automatic test_alert_no_timeout();
        settle();
        write_reg(CFG_ALERT_TO, '0);
        write_reg(CFG_REPROGRAM_TO, 40'hFFFF);
        steady = 1'b1;
        repeat (160) send_item($urandom_range(0, 7) == 0, fresh_tag());
        steady = 1'b0;
        settle();
        write_reg(CFG_MASTER_ID, '0);
    endtask

    task automatic test_sub_learning();
        logic [TAG_W-1:0] a;
        logic [TAG_W-1:0] d;
        send_item(1'b0, rand_tag());
        send_item(1'b1, '0);
        send_item(1'b1, '0);
        send_item(1'b0, '0);
        send_item(1'b1, '0);
        send_item(1'b0, '0);
        a = fresh_tag();
        send_item(1'b1, a);
        send_item(1'b1, a);
        send_item(1'b0, a);
        send_item(1'b1, TAG_ERASED);
        send_item(1'b0, '0);
        send_item(1'b1, fresh_tag());
        d = fresh_tag();
        send_item(1'b1, d);
        send_item(1'b0, d);
        send_item(1'b1, d);
        send_item(1'b0, '0);
        send_item(1'b1, fresh_tag());
        send_item(1'b0, '0);
        send_item(1'b1, fresh_tag());
        send_item(1'b1, a);
    endtask

    task automatic test_random_passes();
        logic [TAG_W-1:0] tag;
        int               sent;
        int               run;
        for (int round = 0; round < 4; round++)
        begin
            settle();
            case (round)
                0: write_reg(CFG_MASTER_ID, TAG_ERASED);
                1: write_reg(CFG_MASTER_ID, rand_tag());
                2: write_reg(CFG_MASTER_ID, lk_table[$urandom_range(SUB_SLOT, SLOTS)]);
                default: write_reg(CFG_MASTER_ID, 40'h00_00C7_EE15);
            endcase
            write_reg(CFG_POWER_ON_TO, round[0] ? 40'hFFFF : 40'($urandom_range(0, 65535)));
            write_reg(CFG_ALERT_TO, 40'($urandom_range(0, 65535)));
            write_reg(CFG_REPROGRAM_TO, 40'($urandom_range(0, 65535)));
            steady = (round == 2);
            sent = 0;
            while (sent < 330)
            begin
                case ($urandom_range(0, 6))
                    0, 1: tag = lk_table[$urandom_range(1, SLOTS)];
                    2:    tag = lk_table[MASTER_SLOT];
                    3:    tag = $urandom_range(0, 1) ? TAG_ERASED : '0;
                    4:    tag = fresh_tag();
                    default: tag = rand_tag();
                endcase
                run = $urandom_range(1, 4);
                repeat (run)
                begin
                    // swap the tag while the reader still holds one
                    if ($urandom_range(0, 7) == 0)
                        tag = rand_tag();
                    send_item(1'b1, tag);
                    sent++;
                end
                repeat ($urandom_range(0, 3))
                begin
                    send_item(1'b0, rand_tag());
                    sent++;
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        lk_mode  = MODE_PWON;
        lk_ticks = '0;
        lk_limit = POWER_ON_TO_RST;
        lk_learn = 0;
        lk_held  = 1'b0;
        lk_tone  = 1'b0;
        for (int s = 1; s <= SLOTS; s++)
            lk_table[s] = TAG_ERASED;
        lk_table[MASTER_SLOT] = MASTER_ID_RST;
        alert_limit_reg = ALERT_TO_RST;
        rprog_limit_reg = REPROGRAM_TO_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_writes();
        test_power_on_timeout();
        test_alert_tone();
        test_reprogram_window();
        test_alert_no_timeout();
        test_sub_learning();
        test_random_passes();
        settle();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
